// ----- design/watchpoint_pool_unit_defines.svh -----
// Assertion macros shared by the watchpoint pool RTL.
`ifndef WATCHPOINT_POOL_UNIT_DEFINES_SVH
`define WATCHPOINT_POOL_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WPP_ASSERT_NOW(lbl, ante, cons, msg)
`define WPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/wpp_pkg.sv -----
// Package with types and constants of the watchpoint pool.
`timescale 1ns / 1ps
`default_nettype none
package wpp_pkg;
  localparam int NumSlots = 32;
  localparam int SlotW    = 5;
  localparam int CntW     = 6;
  localparam int RegW     = 5;
  localparam int NumRegs  = 32;
  localparam int ValW     = 32;

  typedef enum logic [2:0] {
    CMD_UPDATE = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_CHECK  = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NONE     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_ROT    = 2'd1,
    ACT_DROP   = 2'd2,
    ACT_APPEND = 2'd3
  } act_op_e;

  typedef enum logic [1:0] {
    FREE_HOLD = 2'd0,
    FREE_POP  = 2'd1,
    FREE_PUSH = 2'd2
  } free_op_e;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [RegW-1:0]  wreg;
    logic [ValW-1:0]  value;
  } act_ent_t;

  typedef struct packed {
    act_op_e         op;
    logic [CntW-1:0] count;
    act_ent_t        wrap;
  } act_ctl_t;

  typedef struct packed {
    free_op_e         op;
    logic [SlotW-1:0] push_slot;
  } free_ctl_t;
endpackage
`default_nettype wire

// ----- design/wpp_act_cell.sv -----
// One cell of the ordered active watchpoint chain.
`timescale 1ns / 1ps
`default_nettype none
module wpp_act_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [wpp_pkg::SlotW-1:0] cell_idx_i,
  input  wire wpp_pkg::act_ctl_t         ctl_i,
  input  wire wpp_pkg::act_ent_t         nbr_i,
  output wpp_pkg::act_ent_t              ent_o
);
  wpp_pkg::act_ent_t ent_q, ent_d;
  logic [wpp_pkg::CntW-1:0] idx;
  logic is_last, below_last, is_next;

  assign idx        = {1'b0, cell_idx_i};
  assign is_last    = (idx == ctl_i.count - wpp_pkg::CntW'(1)) && (ctl_i.count != '0);
  assign below_last = (idx + wpp_pkg::CntW'(1)) < ctl_i.count;
  assign is_next    = (idx == ctl_i.count);

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      wpp_pkg::ACT_ROT: begin
        if (is_last) ent_d = ctl_i.wrap;
        else if (below_last) ent_d = nbr_i;
      end
      wpp_pkg::ACT_DROP: begin
        if (below_last) ent_d = nbr_i;
      end
      wpp_pkg::ACT_APPEND: begin
        if (is_next) ent_d = ctl_i.wrap;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

// ----- design/wpp_free_cell.sv -----
// One cell of the free slot stack.
`timescale 1ns / 1ps
`default_nettype none
module wpp_free_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [wpp_pkg::SlotW-1:0] cell_idx_i,
  input  wire wpp_pkg::free_ctl_t        ctl_i,
  input  wire logic [wpp_pkg::SlotW-1:0] prev_i,
  input  wire logic [wpp_pkg::SlotW-1:0] next_i,
  output logic [wpp_pkg::SlotW-1:0]      slot_o
);
  logic [wpp_pkg::SlotW-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    case (ctl_i.op)
      wpp_pkg::FREE_POP:  slot_d = next_i;
      wpp_pkg::FREE_PUSH: slot_d = (cell_idx_i == '0) ? ctl_i.push_slot : prev_i;
      default:            slot_d = slot_q;
    endcase
  end

  // Reset loads the cell's own number, giving the free order 0 upward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= cell_idx_i;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

// ----- design/watchpoint_pool_unit.sv -----
// Top level of the watchpoint pool: command sequencer, register mirror and cell chains.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | command, reg_index, reg_value, slot_number
//   out     | output    | out_valid_o/out_ready_i | status, slot_number_res, watched_reg,
//           |           |                         | stored_value, changed, last
//
// Update and allocate complete on acceptance; allocate loads its result into the output register, update gives none.
// Free, check and list walk the active chain of n watchpoints (up to 32), which
// rotates by one cell per cycle; a list walk does so only while the output can take it.
// Reset puts slots 0 to 31 on the free stack, empties the active chain, zeroes the mirror.
// A stalled output holds a list walk and the final free or check result; no new item
// is taken until the current one ends.
`timescale 1ns / 1ps
`default_nettype none
`include "watchpoint_pool_unit_defines.svh"
module watchpoint_pool_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [2:0]                command_i,
  input  wire logic [wpp_pkg::RegW-1:0]  reg_index_i,
  input  wire logic [wpp_pkg::ValW-1:0]  reg_value_i,
  input  wire logic [wpp_pkg::SlotW-1:0] slot_number_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     status_o,
  output logic [wpp_pkg::SlotW-1:0]      slot_number_res_o,
  output logic [wpp_pkg::RegW-1:0]       watched_reg_o,
  output logic [wpp_pkg::ValW-1:0]       stored_value_o,
  output logic                           changed_o,
  output logic                           last_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [2:0] cmd_q, cmd_d;
  logic [wpp_pkg::SlotW-1:0] sn_q, sn_d;
  logic [wpp_pkg::CntW-1:0] steps_q, steps_d, cnt_q, cnt_d, fcnt_q, fcnt_d;
  logic flag_q, flag_d;

  logic [wpp_pkg::ValW-1:0] mirror_q [wpp_pkg::NumRegs];

  logic ov_q, ov_d;
  logic [1:0] st_q, st_d;
  logic [wpp_pkg::SlotW-1:0] os_q, os_d;
  logic [wpp_pkg::RegW-1:0] or_q, or_d;
  logic [wpp_pkg::ValW-1:0] oval_q, oval_d;
  logic oc_q, oc_d, ol_q, ol_d;

  wpp_pkg::act_ctl_t  act_ctl;
  wpp_pkg::free_ctl_t free_ctl;
  wpp_pkg::act_ent_t  act_ent [wpp_pkg::NumSlots];
  logic [wpp_pkg::SlotW-1:0] free_slot [wpp_pkg::NumSlots];

  wpp_pkg::act_ent_t head, alloc_ent;
  logic [wpp_pkg::ValW-1:0] head_mir;
  logic can_emit, accept;

  for (genvar k = 0; k < wpp_pkg::NumSlots; k++) begin : g_cells
    localparam int Nx = (k == wpp_pkg::NumSlots - 1) ? k : k + 1;
    localparam int Pv = (k == 0) ? 0 : k - 1;
    wpp_act_cell u_act (
      .clk_i, .rst_ni,
      .cell_idx_i(wpp_pkg::SlotW'(k)),
      .ctl_i     (act_ctl),
      .nbr_i     (act_ent[Nx]),
      .ent_o     (act_ent[k])
    );
    wpp_free_cell u_free (
      .clk_i, .rst_ni,
      .cell_idx_i(wpp_pkg::SlotW'(k)),
      .ctl_i     (free_ctl),
      .prev_i    (free_slot[Pv]),
      .next_i    (free_slot[Nx]),
      .slot_o    (free_slot[k])
    );
  end

  assign head      = act_ent[0];
  assign head_mir  = mirror_q[head.wreg];
  assign can_emit  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_emit;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    alloc_ent.slot  = free_slot[0];
    alloc_ent.wreg  = reg_index_i;
    alloc_ent.value = mirror_q[reg_index_i];
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; sn_d = sn_q; steps_d = steps_q;
    cnt_d = cnt_q; fcnt_d = fcnt_q; flag_d = flag_q;
    ov_d = ov_q && !out_ready_i;
    st_d = st_q; os_d = os_q; or_d = or_q; oval_d = oval_q; oc_d = oc_q; ol_d = ol_q;
    act_ctl.op = wpp_pkg::ACT_HOLD; act_ctl.count = cnt_q; act_ctl.wrap = head;
    free_ctl.op = wpp_pkg::FREE_HOLD; free_ctl.push_slot = head.slot;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = command_i; sn_d = slot_number_i; steps_d = cnt_q; flag_d = 1'b0;
          st_d = wpp_pkg::ST_OK; os_d = '0; or_d = '0; oval_d = '0; oc_d = 1'b0;
          ol_d = 1'b0;
          case (command_i)
            wpp_pkg::CMD_ALLOC: begin
              ov_d = 1'b1;
              if (fcnt_q == '0) begin
                st_d = wpp_pkg::ST_EMPTY;
              end else begin
                os_d = alloc_ent.slot; or_d = alloc_ent.wreg; oval_d = alloc_ent.value;
                act_ctl.op = wpp_pkg::ACT_APPEND; act_ctl.wrap = alloc_ent;
                free_ctl.op = wpp_pkg::FREE_POP;
                cnt_d = cnt_q + wpp_pkg::CntW'(1);
                fcnt_d = fcnt_q - wpp_pkg::CntW'(1);
              end
            end
            wpp_pkg::CMD_FREE, wpp_pkg::CMD_LIST: begin
              if (cnt_q == '0) begin
                ov_d = 1'b1; st_d = wpp_pkg::ST_NONE;
                ol_d = (command_i == wpp_pkg::CMD_LIST);
              end else begin
                state_d = S_WALK;
              end
            end
            wpp_pkg::CMD_CHECK: state_d = S_WALK;
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          state_d = S_RESP;
        end else if (cmd_q == wpp_pkg::CMD_LIST) begin
          if (can_emit) begin
            ov_d = 1'b1; st_d = wpp_pkg::ST_OK; os_d = head.slot; or_d = head.wreg;
            oval_d = head.value; oc_d = 1'b0; ol_d = (steps_q == wpp_pkg::CntW'(1));
            act_ctl.op = wpp_pkg::ACT_ROT;
            steps_d = steps_q - wpp_pkg::CntW'(1);
            if (steps_q == wpp_pkg::CntW'(1)) state_d = S_IDLE;
          end
        end else if (cmd_q == wpp_pkg::CMD_CHECK) begin
          act_ctl.op = wpp_pkg::ACT_ROT;
          act_ctl.wrap.value = head_mir;
          if (head.value != head_mir) flag_d = 1'b1;
          steps_d = steps_q - wpp_pkg::CntW'(1);
        end else begin
          // Free: the matching slot drops out, all others rotate back in order.
          if (!flag_q && head.slot == sn_q) begin
            act_ctl.op = wpp_pkg::ACT_DROP;
            free_ctl.op = wpp_pkg::FREE_PUSH;
            flag_d = 1'b1;
            cnt_d = cnt_q - wpp_pkg::CntW'(1);
            fcnt_d = fcnt_q + wpp_pkg::CntW'(1);
          end else begin
            act_ctl.op = wpp_pkg::ACT_ROT;
          end
          steps_d = steps_q - wpp_pkg::CntW'(1);
        end
      end
      S_RESP: begin
        if (can_emit) begin
          ov_d = 1'b1; state_d = S_IDLE;
          or_d = '0; oval_d = '0; ol_d = 1'b0;
          if (cmd_q == wpp_pkg::CMD_CHECK) begin
            st_d = wpp_pkg::ST_OK; os_d = '0; oc_d = flag_q;
          end else begin
            st_d = flag_q ? wpp_pkg::ST_OK : wpp_pkg::ST_NOTFOUND;
            os_d = flag_q ? sn_q : '0; oc_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      fcnt_q  <= wpp_pkg::CntW'(wpp_pkg::NumSlots);
      ov_q    <= 1'b0;
      steps_q <= '0;
      flag_q  <= 1'b0;
      cmd_q   <= '0;
      for (int i = 0; i < wpp_pkg::NumRegs; i++) mirror_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fcnt_q  <= fcnt_d;
      ov_q    <= ov_d;
      steps_q <= steps_d;
      flag_q  <= flag_d;
      cmd_q   <= cmd_d;
      if (accept && command_i == wpp_pkg::CMD_UPDATE) mirror_q[reg_index_i] <= reg_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sn_q <= sn_d; st_q <= st_d; os_q <= os_d; or_q <= or_d;
    oval_q <= oval_d; oc_q <= oc_d; ol_q <= ol_d;
  end

  assign out_valid_o       = ov_q;
  assign status_o          = st_q;
  assign slot_number_res_o = os_q;
  assign watched_reg_o     = or_q;
  assign stored_value_o    = oval_q;
  assign changed_o         = oc_q;
  assign last_o            = ol_q;

  `WPP_ASSERT_NOW(a_slots_kept, 1'b1, (cnt_q + fcnt_q) == wpp_pkg::CntW'(wpp_pkg::NumSlots), "slot count mismatch")
  `WPP_ASSERT_NOW(a_steps_bound, state_q == S_WALK, steps_q <= wpp_pkg::CntW'(wpp_pkg::NumSlots), "walk too long")
  `WPP_ASSERT_NEXT(a_walk_ends, state_q == S_WALK && steps_q == '0, state_q == S_RESP, "walk did not end")
endmodule
`default_nettype wire

// ----- dv/wpp_checker.sv -----
// Checker that predicts and compares the watchpoint pool results.
`timescale 1ns / 1ps
module wpp_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [2:0]                command_i,
  input  logic [wpp_pkg::RegW-1:0]  reg_index_i,
  input  logic [wpp_pkg::ValW-1:0]  reg_value_i,
  input  logic [wpp_pkg::SlotW-1:0] slot_number_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [1:0]                status_i,
  input  logic [wpp_pkg::SlotW-1:0] slot_number_res_i,
  input  logic [wpp_pkg::RegW-1:0]  watched_reg_i,
  input  logic [wpp_pkg::ValW-1:0]  stored_value_i,
  input  logic                      changed_i,
  input  logic                      last_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  localparam int NullLink = wpp_pkg::NumSlots;

  typedef struct packed {
    logic [1:0]                status;
    logic [wpp_pkg::SlotW-1:0] slot;
    logic [wpp_pkg::RegW-1:0]  wreg;
    logic [wpp_pkg::ValW-1:0]  value;
    logic                      changed;
    logic                      last;
  } watch_res_t;

  watch_res_t                expected_q[$];
  logic [wpp_pkg::CntW-1:0]  link_r[wpp_pkg::NumSlots];
  logic [wpp_pkg::CntW-1:0]  free_head_r, act_head_r, act_tail_r;
  logic [wpp_pkg::RegW-1:0]  wreg_r[wpp_pkg::NumSlots];
  logic [wpp_pkg::ValW-1:0]  wval_r[wpp_pkg::NumSlots];
  logic [wpp_pkg::ValW-1:0]  mirror_r[wpp_pkg::NumRegs];
  int                        fails;

  assign fail_count_o = fails;

  function automatic watch_res_t mk(logic [1:0] st, int s, int r,
                                    logic [wpp_pkg::ValW-1:0] v, logic c, logic l);
    watch_res_t w;
    w.status = st; w.slot = s[wpp_pkg::SlotW-1:0]; w.wreg = r[wpp_pkg::RegW-1:0];
    w.value = v; w.changed = c; w.last = l;
    return w;
  endfunction

  task automatic predict_watch(logic [2:0] cmd, logic [wpp_pkg::RegW-1:0] ri,
                               logic [wpp_pkg::ValW-1:0] rv,
                               logic [wpp_pkg::SlotW-1:0] sn);
    int s, cur, prev, nx;
    logic chg;
    case (cmd)
      wpp_pkg::CMD_UPDATE: mirror_r[ri] = rv;
      wpp_pkg::CMD_ALLOC: begin
        s = free_head_r;
        if (s >= wpp_pkg::NumSlots) begin
          expected_q.push_back(mk(wpp_pkg::ST_EMPTY, 0, 0, '0, 1'b0, 1'b0));
        end else begin
          free_head_r = link_r[s];
          link_r[s] = wpp_pkg::CntW'(NullLink);
          if (act_tail_r >= wpp_pkg::NumSlots) act_head_r = wpp_pkg::CntW'(s);
          else link_r[act_tail_r] = wpp_pkg::CntW'(s);
          act_tail_r = wpp_pkg::CntW'(s);
          wreg_r[s] = ri;
          wval_r[s] = mirror_r[ri];
          expected_q.push_back(mk(wpp_pkg::ST_OK, s, ri, wval_r[s], 1'b0, 1'b0));
        end
      end
      wpp_pkg::CMD_FREE: begin
        if (act_head_r >= wpp_pkg::NumSlots) begin
          expected_q.push_back(mk(wpp_pkg::ST_NONE, 0, 0, '0, 1'b0, 1'b0));
        end else begin
          prev = NullLink;
          cur = act_head_r;
          while (cur < wpp_pkg::NumSlots && cur != sn) begin
            prev = cur;
            cur = link_r[cur];
          end
          if (cur < wpp_pkg::NumSlots) begin
            nx = link_r[cur];
            if (prev >= wpp_pkg::NumSlots) act_head_r = wpp_pkg::CntW'(nx);
            else link_r[prev] = wpp_pkg::CntW'(nx);
            if (act_tail_r == cur) act_tail_r = wpp_pkg::CntW'(prev);
            link_r[cur] = free_head_r;
            free_head_r = wpp_pkg::CntW'(cur);
            expected_q.push_back(mk(wpp_pkg::ST_OK, cur, 0, '0, 1'b0, 1'b0));
          end else begin
            expected_q.push_back(mk(wpp_pkg::ST_NOTFOUND, 0, 0, '0, 1'b0, 1'b0));
          end
        end
      end
      wpp_pkg::CMD_CHECK: begin
        chg = 1'b0;
        cur = act_head_r;
        while (cur < wpp_pkg::NumSlots) begin
          if (wval_r[cur] != mirror_r[wreg_r[cur]]) begin
            chg = 1'b1;
            wval_r[cur] = mirror_r[wreg_r[cur]];
          end
          cur = link_r[cur];
        end
        expected_q.push_back(mk(wpp_pkg::ST_OK, 0, 0, '0, chg, 1'b0));
      end
      wpp_pkg::CMD_LIST: begin
        if (act_head_r >= wpp_pkg::NumSlots) begin
          expected_q.push_back(mk(wpp_pkg::ST_NONE, 0, 0, '0, 1'b0, 1'b1));
        end else begin
          cur = act_head_r;
          while (cur < wpp_pkg::NumSlots) begin
            nx = link_r[cur];
            expected_q.push_back(mk(wpp_pkg::ST_OK, cur, wreg_r[cur], wval_r[cur], 1'b0,
                                    nx >= wpp_pkg::NumSlots));
            cur = nx;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    watch_res_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < wpp_pkg::NumSlots; i++) link_r[i] = wpp_pkg::CntW'(i + 1);
      for (int i = 0; i < wpp_pkg::NumRegs; i++) mirror_r[i] = '0;
      free_head_r = '0;
      act_head_r  = wpp_pkg::CntW'(NullLink);
      act_tail_r  = wpp_pkg::CntW'(NullLink);
      fails       = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = mk(status_i, slot_number_res_i, watched_reg_i, stored_value_i, changed_i,
                 last_i);
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", got);
          fails = fails + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("mismatch: expected st=%0d slot=%0d reg=%0d val=%h chg=%b last=%b,",
                       want.status, want.slot, want.wreg, want.value, want.changed,
                       want.last, " got st=%0d slot=%0d reg=%0d val=%h chg=%b last=%b",
                       got.status, got.slot, got.wreg, got.value, got.changed, got.last);
            fails = fails + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_watch(command_i, reg_index_i, reg_value_i, slot_number_i);
    end
    pending_o = expected_q.size();
  end
endmodule

// ----- dv/tb.sv -----
// Testbench top of the watchpoint pool: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [2:0]                command_i = '0;
  logic [wpp_pkg::RegW-1:0]  reg_index_i = '0;
  logic [wpp_pkg::ValW-1:0]  reg_value_i = '0;
  logic [wpp_pkg::SlotW-1:0] slot_number_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                status_o;
  logic [wpp_pkg::SlotW-1:0] slot_number_res_o;
  logic [wpp_pkg::RegW-1:0]  watched_reg_o;
  logic [wpp_pkg::ValW-1:0]  stored_value_o;
  logic                      changed_o, last_o;
  int                        fail_count, pending;
  bit                        calm;

  always #2 clk_i = ~clk_i;

  watchpoint_pool_unit uut (.*);

  wpp_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .reg_index_i,
    .reg_value_i, .slot_number_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .slot_number_res_i(slot_number_res_o), .watched_reg_i(watched_reg_o),
    .stored_value_i(stored_value_o), .changed_i(changed_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random except during the calm stretch.
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 21);

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_item(logic [2:0] cmd, logic [wpp_pkg::RegW-1:0] ri,
                           logic [wpp_pkg::ValW-1:0] rv, logic [wpp_pkg::SlotW-1:0] sn);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i     <= cmd;
    reg_index_i   <= ri;
    reg_value_i   <= rv;
    slot_number_i <= sn;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30) send_item(wpp_pkg::CMD_UPDATE, $urandom, $urandom, $urandom);
    else if (r < 55) send_item(wpp_pkg::CMD_ALLOC, $urandom, $urandom, $urandom);
    else if (r < 78) send_item(wpp_pkg::CMD_FREE, $urandom, $urandom, $urandom);
    else if (r < 88) send_item(wpp_pkg::CMD_CHECK, $urandom, $urandom, $urandom);
    else if (r < 96) send_item(wpp_pkg::CMD_LIST, $urandom, $urandom, $urandom);
    else send_item(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Empty pool cases, then fill all slots and overflow.
    send_item(wpp_pkg::CMD_FREE, '0, '0, 5'd3);
    send_item(wpp_pkg::CMD_LIST, '0, '0, '0);
    send_item(wpp_pkg::CMD_CHECK, '0, '0, '0);
    send_item(wpp_pkg::CMD_UPDATE, 5'd31, 32'hFFFF_FFFF, '0);
    send_item(wpp_pkg::CMD_UPDATE, 5'd0, 32'h0, 5'd31);
    for (int i = 0; i < wpp_pkg::NumSlots; i++)
      send_item(wpp_pkg::CMD_ALLOC, wpp_pkg::RegW'(31 - i), '0, '0);
    send_item(wpp_pkg::CMD_ALLOC, 5'd1, '0, '0);
    send_item(wpp_pkg::CMD_LIST, '0, '0, '0);
    send_item(wpp_pkg::CMD_UPDATE, 5'd31, 32'h1234_5678, '0);
    send_item(wpp_pkg::CMD_CHECK, '0, '0, '0);
    send_item(wpp_pkg::CMD_CHECK, '0, '0, '0);
    send_item(wpp_pkg::CMD_FREE, '0, '0, 5'd31);
    send_item(wpp_pkg::CMD_FREE, '0, '0, 5'd0);
    send_item(wpp_pkg::CMD_FREE, '0, '0, 5'd0);
    send_item(wpp_pkg::CMD_FREE, '0, '0, 5'd15);
    send_item(3'd7, '1, '1, '1);
    send_item(wpp_pkg::CMD_ALLOC, 5'd7, '0, '0);
    send_item(wpp_pkg::CMD_LIST, '0, '0, '0);
    for (int i = 0; i < 430; i++) begin
      calm = (i >= 200 && i < 280);
      random_item();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #8ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
